FILE: design/emr_pkg.sv
// ----------------------------------------------------------------------------
// emr_pkg: shared types and constants for the int8 elementwise multiply block
// Field widths, register index codes, reset values and pipeline depth.
// ----------------------------------------------------------------------------
package emr_pkg;

    localparam int VAL_W      = 8;    // input operand bytes
    localparam int OFF_W      = 9;    // operand offsets
    localparam int ROFF_W     = 8;    // result offset
    localparam int MULT_W     = 32;   // requant multiplier
    localparam int SHIFT_W    = 6;    // requant shift
    localparam int OUT_W      = 8;    // result byte
    localparam int SUM_W      = 10;   // operand + offset
    localparam int PROD_W     = 2 * SUM_W;
    localparam int ACC_W      = 32;
    localparam int WIDE_W     = 2 * ACC_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int NSTAGE     = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_OFFSET  = 3'd0,
        REG_SECOND_OFFSET = 3'd1,
        REG_RESULT_OFFSET = 3'd2,
        REG_REQUANT_MULT  = 3'd3,
        REG_REQUANT_SHIFT = 3'd4,
        REG_CLAMP_LOW     = 3'd5,
        REG_CLAMP_HIGH    = 3'd6
    } t_reg_idx;

    localparam logic signed [MULT_W-1:0] MULT_RST       = 32'sh4000_0000;
    localparam logic signed [OUT_W-1:0]  CLAMP_LOW_RST  = 8'sh80;
    localparam logic signed [OUT_W-1:0]  CLAMP_HIGH_RST = 8'sh7F;

    localparam logic signed [ACC_W-1:0]  ACC_MIN = 32'sh8000_0000;
    localparam logic signed [ACC_W-1:0]  ACC_MAX = 32'sh7FFF_FFFF;

    // rounding nudge of the doubling high multiply, by sign of the product
    localparam logic signed [WIDE_W-1:0] NUDGE_POS = 64'sh0000_0000_4000_0000;
    localparam logic signed [WIDE_W-1:0] NUDGE_NEG = 64'shFFFF_FFFF_C000_0001;
    // bias that turns the floor shift into truncation toward zero
    localparam logic signed [WIDE_W-1:0] TRUNC_BIAS = 64'sh0000_0000_7FFF_FFFF;

endpackage

FILE: design/emr_in_if.sv
// ----------------------------------------------------------------------------
// emr_in_if: operand stream channel
// Valid/ready channel carrying one operand pair and the last-element flag.
// ----------------------------------------------------------------------------
interface emr_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [emr_pkg::VAL_W-1:0]     first_value;
    logic signed [emr_pkg::VAL_W-1:0]     second_value;
    logic                                 is_last;

    modport source (output valid, output first_value, output second_value,
                    output is_last, input ready);
    modport sink   (input valid, input first_value, input second_value,
                    input is_last, output ready);
endinterface

FILE: design/emr_out_if.sv
// ----------------------------------------------------------------------------
// emr_out_if: result stream channel
// Valid/ready channel carrying one requantized byte and the last-element flag.
// ----------------------------------------------------------------------------
interface emr_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [emr_pkg::OUT_W-1:0]     product_byte;
    logic                                 last_out;

    modport source (output valid, output product_byte, output last_out,
                    input ready);
    modport sink   (input valid, input product_byte, input last_out,
                    output ready);
endinterface

FILE: design/int8_elementwise_mul_requant_top.sv
// ----------------------------------------------------------------------------
// int8_elementwise_mul_requant_top: int8 elementwise multiply with requant
// Offsets two signed bytes, multiplies them, requantizes with a Q31 multiplier
// and signed shift, adds the output offset and clamps to the activation range.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  --------  ---  ---------------  ----------------------------------------
//  i_in      in   valid / ready    first_value, second_value, is_last
//  o_out     out  valid / ready    product_byte, last_out
//  i_cfg_*   in   write enable     register index, write data
//
//  One transaction per cycle sustained while o_out is ready, through an
//  8-stage pipeline (offset add, 10x10 multiply, left shift, 32x32 multiply,
//  nudge add, truncation, rounding right shift, offset add and clamp).
//  Each stage holds its data while the next one is full and stalled, so
//  bubbles are squeezed out and nothing is lost or repeated.
//  Synchronous active-low reset clears the valid bits and loads the configuration registers with their reset values.
//
module int8_elementwise_mul_requant_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    emr_in_if.sink                                i_in,
    emr_out_if.source                             o_out,
    input  logic                                  i_cfg_we,
    input  logic [emr_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [emr_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);

    localparam int N = emr_pkg::NSTAGE;

    // configuration registers
    logic signed [emr_pkg::OFF_W-1:0]   r_first_off;
    logic signed [emr_pkg::OFF_W-1:0]   r_second_off;
    logic signed [emr_pkg::ROFF_W-1:0]  r_result_off;
    logic signed [emr_pkg::MULT_W-1:0]  r_mult;
    logic signed [emr_pkg::SHIFT_W-1:0] r_shift;
    logic signed [emr_pkg::OUT_W-1:0]   r_clamp_low;
    logic signed [emr_pkg::OUT_W-1:0]   r_clamp_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_off  <= '0;
            r_second_off <= '0;
            r_result_off <= '0;
            r_mult       <= emr_pkg::MULT_RST;
            r_shift      <= '0;
            r_clamp_low  <= emr_pkg::CLAMP_LOW_RST;
            r_clamp_high <= emr_pkg::CLAMP_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (emr_pkg::t_reg_idx'(i_cfg_idx))
                emr_pkg::REG_FIRST_OFFSET:  r_first_off  <= i_cfg_wdata[emr_pkg::OFF_W-1:0];
                emr_pkg::REG_SECOND_OFFSET: r_second_off <= i_cfg_wdata[emr_pkg::OFF_W-1:0];
                emr_pkg::REG_RESULT_OFFSET: r_result_off <= i_cfg_wdata[emr_pkg::ROFF_W-1:0];
                emr_pkg::REG_REQUANT_MULT:  r_mult       <= i_cfg_wdata[emr_pkg::MULT_W-1:0];
                emr_pkg::REG_REQUANT_SHIFT: r_shift      <= i_cfg_wdata[emr_pkg::SHIFT_W-1:0];
                emr_pkg::REG_CLAMP_LOW:     r_clamp_low  <= i_cfg_wdata[emr_pkg::OUT_W-1:0];
                emr_pkg::REG_CLAMP_HIGH:    r_clamp_high <= i_cfg_wdata[emr_pkg::OUT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: a stage loads when it is empty or its data moves on
    // ------------------------------------------------------------------
    logic [N-1:0] r_vld;
    logic [N-1:0] r_last;
    logic [N-1:0] w_adv;

    always_comb begin
        w_adv[N-1] = !r_vld[N-1] || o_out.ready;
        for (int k = N - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < N; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_last[0] <= i_in.is_last;
        end
        for (int k = 1; k < N; k++) begin
            if (w_adv[k]) begin
                r_last[k] <= r_last[k-1];
            end
        end
    end

    assign i_in.ready = w_adv[0];

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    logic signed [emr_pkg::SUM_W-1:0]  r_a;
    logic signed [emr_pkg::SUM_W-1:0]  r_b;
    logic signed [emr_pkg::PROD_W-1:0] r_prod;
    logic signed [emr_pkg::ACC_W-1:0]  r_x;
    logic signed [emr_pkg::WIDE_W-1:0] r_wide;
    logic                              r_neg;
    logic [1:0]                        r_sat;   // both operands at the minimum
    logic signed [emr_pkg::WIDE_W-1:0] r_nudged;
    logic signed [emr_pkg::ACC_W-1:0]  r_hm;
    logic signed [emr_pkg::ACC_W-1:0]  r_rs;
    logic signed [emr_pkg::OUT_W-1:0]  r_out;

    logic signed [emr_pkg::ACC_W-1:0]  w_prod_ext;
    logic                              w_shl;
    logic                              w_shr;
    logic signed [emr_pkg::WIDE_W-1:0] w_trunc;
    logic [emr_pkg::SHIFT_W-1:0]       w_e;
    logic signed [emr_pkg::ACC_W:0]    w_x33;
    logic signed [emr_pkg::ACC_W:0]    w_floor;
    logic [emr_pkg::ACC_W:0]           w_mask;
    logic [emr_pkg::ACC_W:0]           w_rem;
    logic [emr_pkg::ACC_W:0]           w_thr;
    logic signed [emr_pkg::ACC_W-1:0]  w_rounded;
    logic signed [emr_pkg::ACC_W:0]    w_sum;
    logic signed [emr_pkg::ACC_W:0]    w_lo;
    logic signed [emr_pkg::ACC_W:0]    w_hi;
    logic signed [emr_pkg::ACC_W:0]    w_clamped;

    assign w_shl = !r_shift[emr_pkg::SHIFT_W-1] && (r_shift != '0);
    assign w_shr = r_shift[emr_pkg::SHIFT_W-1];
    assign w_prod_ext = {{(emr_pkg::ACC_W - emr_pkg::PROD_W){r_prod[emr_pkg::PROD_W-1]}},
                         r_prod};

    // truncating divide by 2^31: bias negative values before the floor shift
    assign w_trunc = r_nudged[emr_pkg::WIDE_W-1] ? r_nudged + emr_pkg::TRUNC_BIAS : r_nudged;

    // rounding right shift, half away from zero; a shift of 32 works in 33 bits
    always_comb begin
        w_e     = emr_pkg::SHIFT_W'(-r_shift);
        w_x33   = {r_hm[emr_pkg::ACC_W-1], r_hm};
        w_floor = w_x33 >>> w_e;
        w_mask  = (33'd1 << w_e) - 33'd1;
        w_rem   = w_x33 & w_mask;
        w_thr   = (w_mask >> 1) + {32'd0, w_floor[emr_pkg::ACC_W]};
        w_rounded = w_floor[emr_pkg::ACC_W-1:0] + ((w_rem > w_thr) ? 32'sd1 : 32'sd0);
    end

    // output offset and clamp, low bound first so inverted bounds give high
    always_comb begin
        w_sum = {r_rs[emr_pkg::ACC_W-1], r_rs}
              + {{(emr_pkg::ACC_W + 1 - emr_pkg::ROFF_W){r_result_off[emr_pkg::ROFF_W-1]}},
                 r_result_off};
        w_lo  = {{(emr_pkg::ACC_W + 1 - emr_pkg::OUT_W){r_clamp_low[emr_pkg::OUT_W-1]}},
                 r_clamp_low};
        w_hi  = {{(emr_pkg::ACC_W + 1 - emr_pkg::OUT_W){r_clamp_high[emr_pkg::OUT_W-1]}},
                 r_clamp_high};
        w_clamped = (w_sum < w_lo) ? w_lo : w_sum;
        if (w_clamped > w_hi) begin
            w_clamped = w_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_a <= {{(emr_pkg::SUM_W - emr_pkg::VAL_W){i_in.first_value[emr_pkg::VAL_W-1]}},
                    i_in.first_value}
                 + {r_first_off[emr_pkg::OFF_W-1], r_first_off};
            r_b <= {{(emr_pkg::SUM_W - emr_pkg::VAL_W){i_in.second_value[emr_pkg::VAL_W-1]}},
                    i_in.second_value}
                 + {r_second_off[emr_pkg::OFF_W-1], r_second_off};
        end
        if (w_adv[1]) begin
            r_prod <= r_a * r_b;
        end
        if (w_adv[2]) begin
            r_x <= w_shl ? (w_prod_ext << r_shift[emr_pkg::SHIFT_W-2:0]) : w_prod_ext;
        end
        if (w_adv[3]) begin
            r_wide   <= r_x * r_mult;
            r_neg    <= r_x[emr_pkg::ACC_W-1] ^ r_mult[emr_pkg::MULT_W-1];
            r_sat[0] <= (r_x == emr_pkg::ACC_MIN) && (r_mult == emr_pkg::ACC_MIN);
        end
        if (w_adv[4]) begin
            r_nudged <= r_wide + (r_neg ? emr_pkg::NUDGE_NEG : emr_pkg::NUDGE_POS);
            r_sat[1] <= r_sat[0];
        end
        if (w_adv[5]) begin
            r_hm <= r_sat[1] ? emr_pkg::ACC_MAX : w_trunc[2*emr_pkg::ACC_W-2:emr_pkg::ACC_W-1];
        end
        if (w_adv[6]) begin
            r_rs <= w_shr ? w_rounded : r_hm;
        end
        if (w_adv[7]) begin
            r_out <= w_clamped[emr_pkg::OUT_W-1:0];
        end
    end

    assign o_out.valid        = r_vld[N-1];
    assign o_out.product_byte = r_out;
    assign o_out.last_out     = r_last[N-1];

endmodule

FILE: tb/sv/requant_product_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// requant_product_checker: result checker for the int8 multiply/requant block
// Shadows the register file from the config port, predicts the requantized
// byte of every operand pair taken on the input channel and compares each
// result transaction, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module requant_product_checker
    import emr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    emr_in_if                     in_ch,
    emr_out_if                    out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_checked
);

    localparam longint Q31_SCALE  = 64'sd2147483648;
    localparam longint HALF_NUDGE = 64'sd1073741824;
    localparam int     PRINT_MAX  = 50;

    typedef struct packed {
        logic signed [OUT_W-1:0] product_byte;
        logic                    last_out;
    } t_product;

    logic signed [OFF_W-1:0]   first_off;
    logic signed [OFF_W-1:0]   second_off;
    logic signed [ROFF_W-1:0]  result_off;
    logic signed [MULT_W-1:0]  mult;
    logic signed [SHIFT_W-1:0] shift_amt;
    logic signed [OUT_W-1:0]   clamp_lo;
    logic signed [OUT_W-1:0]   clamp_hi;

    t_product expected_products[$];
    int       mismatch_count = 0;
    int       checked_count  = 0;

    assign o_mismatches = mismatch_count;
    assign o_checked    = checked_count;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_MAX) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function automatic logic signed [OUT_W-1:0] predict_product(
        input logic signed [VAL_W-1:0] lhs,
        input logic signed [VAL_W-1:0] rhs
    );
        longint      acc;
        longint      nudge;
        longint      mask;
        longint      rem_bits;
        longint      half;
        logic [31:0] wrapped;
        int          rshift;
        acc = (longint'(lhs) + longint'(first_off)) * (longint'(rhs) + longint'(second_off));
        // left shift wraps to 32 bits before the high multiply
        if (shift_amt > 0) begin
            wrapped = acc[31:0] << int'(shift_amt);
            acc = longint'(signed'(wrapped));
        end
        if (acc == longint'(ACC_MIN) && longint'(mult) == longint'(ACC_MIN)) begin
            acc = longint'(ACC_MAX);
        end else begin
            nudge = ((acc < 0) != (mult < 0)) ? 64'sd1 - HALF_NUDGE : HALF_NUDGE;
            acc = (acc * longint'(mult) + nudge) / Q31_SCALE;
        end
        // round half away from zero; shift may reach 32
        if (shift_amt < 0) begin
            rshift   = -int'(shift_amt);
            mask     = (64'sd1 <<< rshift) - 64'sd1;
            rem_bits = acc & mask;
            acc      = acc >>> rshift;
            half     = mask >>> 1;
            if (acc < 0) begin
                half++;
            end
            if (rem_bits > half) begin
                acc++;
            end
        end
        acc = acc + longint'(result_off);
        // low bound first, so inverted bounds settle on clamp_hi
        if (acc < longint'(clamp_lo)) begin
            acc = longint'(clamp_lo);
        end
        if (acc > longint'(clamp_hi)) begin
            acc = longint'(clamp_hi);
        end
        return acc[OUT_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            first_off  <= '0;
            second_off <= '0;
            result_off <= '0;
            mult       <= MULT_RST;
            shift_amt  <= '0;
            clamp_lo   <= CLAMP_LOW_RST;
            clamp_hi   <= CLAMP_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FIRST_OFFSET:  first_off  <= i_cfg_wdata[OFF_W-1:0];
                REG_SECOND_OFFSET: second_off <= i_cfg_wdata[OFF_W-1:0];
                REG_RESULT_OFFSET: result_off <= i_cfg_wdata[ROFF_W-1:0];
                REG_REQUANT_MULT:  mult       <= i_cfg_wdata[MULT_W-1:0];
                REG_REQUANT_SHIFT: shift_amt  <= i_cfg_wdata[SHIFT_W-1:0];
                REG_CLAMP_LOW:     clamp_lo   <= i_cfg_wdata[OUT_W-1:0];
                REG_CLAMP_HIGH:    clamp_hi   <= i_cfg_wdata[OUT_W-1:0];
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin : track
        t_product got;
        t_product want;
        if (!i_rst_n) begin
            expected_products.delete();
            o_pending <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.product_byte, out_ch.last_out};
                if (expected_products.size() == 0) begin
                    report_mismatch($sformatf("result %0d last=%0b with nothing expected",
                                              got.product_byte, got.last_out));
                end else begin
                    want = expected_products.pop_front();
                    checked_count++;
                    if (got.product_byte !== want.product_byte) begin
                        report_mismatch($sformatf("product_byte %0d, expected %0d",
                                                  got.product_byte, want.product_byte));
                    end
                    if (got.last_out !== want.last_out) begin
                        report_mismatch($sformatf("last_out %0b, expected %0b",
                                                  got.last_out, want.last_out));
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                expected_products.push_back('{predict_product(in_ch.first_value,
                                                              in_ch.second_value),
                                              in_ch.is_last});
            end
            o_pending <= expected_products.size();
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for int8_elementwise_mul_requant_top
// Drives operand pairs and register settings with random gaps and output
// stalls: a directed set at the corners of the requantizer, then random
// phases with fresh settings; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import emr_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 80;
    localparam int IDLE_PCT      = 17;
    localparam int NUM_IDX       = 1 << CFG_IDX_W;

    typedef struct packed {
        logic signed [OFF_W-1:0]   first_off;
        logic signed [OFF_W-1:0]   second_off;
        logic signed [ROFF_W-1:0]  result_off;
        logic signed [MULT_W-1:0]  mult;
        logic signed [SHIFT_W-1:0] shift;
        logic signed [OUT_W-1:0]   clamp_lo;
        logic signed [OUT_W-1:0]   clamp_hi;
    } t_requant_settings;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  steady_flow = 1'b0;
    int                    cycle_count = 0;
    int                    pairs_sent = 0;
    int                    settings_applied = 0;
    int                    mismatches;
    int                    pending;
    int                    checked;

    emr_in_if  in_ch ();
    emr_out_if out_ch ();

    int8_elementwise_mul_requant_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    requant_product_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // result side backpressure
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic t_requant_settings make_settings(
        input logic signed [OFF_W-1:0]   first_off,
        input logic signed [OFF_W-1:0]   second_off,
        input logic signed [ROFF_W-1:0]  result_off,
        input logic signed [MULT_W-1:0]  mult,
        input logic signed [SHIFT_W-1:0] shift,
        input logic signed [OUT_W-1:0]   clamp_lo,
        input logic signed [OUT_W-1:0]   clamp_hi
    );
        return '{first_off, second_off, result_off, mult, shift, clamp_lo, clamp_hi};
    endfunction

    function automatic logic signed [OFF_W-1:0] pick_offset();
        case ($urandom_range(9))
            0:       return OFF_W'($urandom());
            1:       return $urandom_range(1) ? 9'sd128 : -9'sd127;
            default: return OFF_W'($urandom_range(255)) - 9'sd127;
        endcase
    endfunction

    function automatic t_requant_settings random_settings();
        t_requant_settings s;
        s.first_off  = pick_offset();
        s.second_off = pick_offset();
        s.result_off = ROFF_W'($urandom());
        case ($urandom_range(5))
            0: s.mult = $urandom();
            1: begin
                case ($urandom_range(2))
                    0:       s.mult = ACC_MIN;
                    1:       s.mult = ACC_MAX;
                    default: s.mult = '0;
                endcase
            end
            default: s.mult = MULT_RST + MULT_W'($urandom_range(32'h3FFF_FFFF));
        endcase
        case ($urandom_range(5))
            0:       s.shift = SHIFT_W'($urandom());
            1:       s.shift = $urandom_range(1) ? 6'sd31 : 6'h20;
            default: s.shift = -SHIFT_W'($urandom_range(11, 4));
        endcase
        if ($urandom_range(3) == 0) begin
            s.clamp_lo = OUT_W'($urandom());
            s.clamp_hi = OUT_W'($urandom());
        end else begin
            s.clamp_lo = CLAMP_LOW_RST + OUT_W'($urandom_range(40));
            s.clamp_hi = CLAMP_HIGH_RST - OUT_W'($urandom_range(40));
        end
        return s;
    endfunction

    // Writes every index in turn; unused upper data bits carry junk and the
    // unmapped top index gets random data that must be ignored.
    task automatic program_settings(input t_requant_settings s);
        logic [CFG_DATA_W-1:0] word [NUM_IDX];
        for (int k = 0; k < NUM_IDX; k++) begin
            word[k] = $urandom();
        end
        word[REG_FIRST_OFFSET][OFF_W-1:0]   = s.first_off;
        word[REG_SECOND_OFFSET][OFF_W-1:0]  = s.second_off;
        word[REG_RESULT_OFFSET][ROFF_W-1:0] = s.result_off;
        word[REG_REQUANT_MULT]              = s.mult;
        word[REG_REQUANT_SHIFT][SHIFT_W-1:0] = s.shift;
        word[REG_CLAMP_LOW][OUT_W-1:0]      = s.clamp_lo;
        word[REG_CLAMP_HIGH][OUT_W-1:0]     = s.clamp_hi;
        for (int k = 0; k < NUM_IDX; k++) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= CFG_IDX_W'(k);
            cfg_wdata <= word[k];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    task automatic send_pair(
        input logic signed [VAL_W-1:0] lhs,
        input logic signed [VAL_W-1:0] rhs,
        input logic                    last
    );
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.first_value  <= lhs;
        in_ch.second_value <= rhs;
        in_ch.is_last      <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        pairs_sent++;
    endtask

    // pending is registered in the checker, so step the clock before testing it
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= '0;
        cfg_wdata          <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.first_value  <= '0;
        in_ch.second_value <= '0;
        in_ch.is_last      <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values, operand corners
        send_pair(-8'sd128, -8'sd128, 1'b0);
        send_pair(8'sd127, 8'sd127, 1'b1);
        send_pair(-8'sd128, 8'sd127, 1'b0);
        send_pair(8'sd127, -8'sd128, 1'b0);
        send_pair(8'sd0, 8'sd0, 1'b1);
        send_pair(-8'sd1, 8'sd1, 1'b0);
        wait_drained();

        // shift left by 31 wraps to INT32_MIN; with INT32_MIN multiplier saturates
        program_settings(make_settings(9'sd0, 9'sd0, 8'sd0, ACC_MIN, 6'sd31,
                                       CLAMP_LOW_RST, CLAMP_HIGH_RST));
        send_pair(8'sd1, 8'sd1, 1'b1);
        send_pair(-8'sd1, -8'sd1, 1'b0);
        send_pair(8'sd2, 8'sd3, 1'b0);
        wait_drained();

        // rounding right shift by 32, offsets at their nominal extremes
        program_settings(make_settings(9'sd128, -9'sd127, 8'sd0, ACC_MAX, 6'h20,
                                       CLAMP_LOW_RST, CLAMP_HIGH_RST));
        send_pair(8'sd127, 8'sd127, 1'b0);
        send_pair(-8'sd128, 8'sd127, 1'b1);
        send_pair(8'sd0, 8'sd0, 1'b0);
        wait_drained();

        // inverted activation bounds
        program_settings(make_settings(9'sd0, 9'sd0, 8'sd5, MULT_RST, 6'sd0,
                                       8'sd100, -8'sd100));
        send_pair(8'sd10, 8'sd10, 1'b0);
        send_pair(-8'sd128, -8'sd128, 1'b1);
        send_pair(8'sd127, -8'sd128, 1'b0);
        wait_drained();

        // offsets at the ends of their 9-bit range
        program_settings(make_settings(9'h100, 9'h0FF, -8'sd128, ACC_MAX, -6'sd8,
                                       CLAMP_LOW_RST, CLAMP_HIGH_RST));
        send_pair(-8'sd128, 8'sd127, 1'b0);
        send_pair(8'sd127, -8'sd128, 1'b0);
        send_pair(-8'sd128, -8'sd128, 1'b1);
        send_pair(8'sd127, 8'sd127, 1'b0);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            steady_flow = (ph == 2);
            program_settings(random_settings());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_pair(VAL_W'($urandom()), VAL_W'($urandom()), $urandom_range(7) == 0);
            end
            wait_drained();
        end
        steady_flow = 1'b0;
        repeat (NSTAGE * 4) @(posedge i_clk);

        $display("Covered %0d operand pairs under %0d register settings, including",
                 pairs_sent, settings_applied);
        $display("saturation, shift -32, inverted bounds; %0d results compared in %0d cycles.",
                 checked, cycle_count);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: int8_elementwise_mul_requant_top.f
design/emr_pkg.sv
design/emr_in_if.sv
design/emr_out_if.sv
design/int8_elementwise_mul_requant_top.sv
tb/sv/requant_product_checker.sv
tb/sv/tb_top.sv
